[rtl/core/assert_macros.svh]
// assertion macros shared by the angle text parser rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

[rtl/core/datp_pkg.sv]
// types and constants of the angle text parser
// no dependencies; used by all but assert_macros.svh
`default_nettype none

package datp_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W = 2;

   localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

   localparam logic [7:0] DEG_SYM_RESET = 8'd176;
   localparam logic [7:0] MIN_SYM_RESET = 8'd39;
   localparam logic [7:0] SEC_SYM_RESET = 8'd34;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_W     = 8'h57;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEGREE_SYMBOL = 2'd0,
      CSR_MINUTE_SYMBOL = 2'd1,
      CSR_SECOND_SYMBOL = 2'd2
   } datp_csr_index_type;

   typedef enum logic [1:0] {
      PH_SPACE  = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_DONE   = 2'd3
   } datp_phase_type;

   typedef enum logic [1:0] {
      FR_NONE    = 2'd0,
      FR_ZERO    = 2'd1,
      FR_NONZERO = 2'd2
   } datp_frac_type;

   // one classified character
   typedef struct packed {
      logic [7:0] text_char;
      logic       is_last;
      logic       digit;
      logic [3:0] digit_val;
      logic       digit_nz;
      logic       space;
      logic       plus;
      logic       minus;
      logic       dot;
      logic       sign_char;
      logic       sign_neg;
      logic       match_d;
      logic       match_m;
      logic       match_s;
   } datp_class_type;

   typedef struct packed {
      datp_phase_type phase;
      logic           neg;
      logic [30:0]    value;
   } datp_scan_type;

   // final scanner state of one text
   typedef struct packed {
      logic        is_negative;
      logic [7:0]  sign_char;
      logic [2:0]  symbols;
      logic [30:0] deg_val;
      logic        min_neg;
      logic [30:0] min_val;
      logic        sec_neg;
      logic [30:0] sec_val;
      logic        frac_nz;
   } datp_snap_type;

endpackage

`default_nettype wire

[rtl/core/datp_if.sv]
// channel interfaces of the angle text parser: text in, result out, csr write
// depends on datp_pkg
`default_nettype none

interface datp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       is_last;
   modport source (output valid, text_char, is_last, input ready);
   modport sink (input valid, text_char, is_last, output ready);
endinterface

interface datp_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_negative;
   logic [7:0]  sign_char;
   logic [30:0] degrees;
   logic [31:0] minutes;
   logic [31:0] seconds;
   modport source (output valid, is_negative, sign_char, degrees, minutes, seconds,
                   input ready);
   modport sink (input valid, is_negative, sign_char, degrees, minutes, seconds,
                 output ready);
endinterface

interface datp_csr_if;
   logic                             valid;
   logic                             ready;
   logic [datp_pkg::CSR_INDEX_W-1:0] index;
   logic [7:0]                       data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/datp_front.sv]
// front end: symbol registers, character classification and push into the queue
// depends on datp_pkg and datp_if
`default_nettype none

module datp_front (
   input  wire logic             clock,
   input  wire logic             reset,
   datp_req_if.sink              req_bus,
   datp_csr_if.sink              csr_bus,
   input  wire logic             q_full,
   output logic                  push,
   output datp_pkg::datp_class_type push_item
);

   logic [7:0] deg_sym_ff, deg_sym_in;
   logic [7:0] min_sym_ff, min_sym_in;
   logic [7:0] sec_sym_ff, sec_sym_in;
   logic [7:0] c;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !q_full;
   assign push          = req_bus.valid && !q_full;

   always_comb begin
      deg_sym_in = deg_sym_ff;
      min_sym_in = min_sym_ff;
      sec_sym_in = sec_sym_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            datp_pkg::CSR_DEGREE_SYMBOL: deg_sym_in = csr_bus.data;
            datp_pkg::CSR_MINUTE_SYMBOL: min_sym_in = csr_bus.data;
            datp_pkg::CSR_SECOND_SYMBOL: sec_sym_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deg_sym_ff <= datp_pkg::DEG_SYM_RESET;
         min_sym_ff <= datp_pkg::MIN_SYM_RESET;
         sec_sym_ff <= datp_pkg::SEC_SYM_RESET;
      end else begin
         deg_sym_ff <= deg_sym_in;
         min_sym_ff <= min_sym_in;
         sec_sym_ff <= sec_sym_in;
      end
   end

   assign c = req_bus.text_char;

   always_comb begin
      push_item.text_char = c;
      push_item.is_last   = req_bus.is_last;
      push_item.digit     = (c >= datp_pkg::CH_ZERO) && (c <= datp_pkg::CH_NINE);
      push_item.digit_val = c[3:0];
      push_item.digit_nz  = push_item.digit && (c != datp_pkg::CH_ZERO);
      push_item.space     = (c == datp_pkg::CH_SPACE) ||
                            ((c >= datp_pkg::CH_TAB) && (c <= datp_pkg::CH_CR));
      push_item.plus      = (c == datp_pkg::CH_PLUS);
      push_item.minus     = (c == datp_pkg::CH_MINUS);
      push_item.dot       = (c == datp_pkg::CH_DOT);
      push_item.sign_char = (c == datp_pkg::CH_PLUS) || (c == datp_pkg::CH_MINUS) ||
                            (c == datp_pkg::CH_N) || (c == datp_pkg::CH_S) ||
                            (c == datp_pkg::CH_E) || (c == datp_pkg::CH_W);
      push_item.sign_neg  = (c == datp_pkg::CH_MINUS) || (c == datp_pkg::CH_S) ||
                            (c == datp_pkg::CH_W);
      push_item.match_d   = (c == deg_sym_ff);
      push_item.match_m   = (c == min_sym_ff);
      push_item.match_s   = (c == sec_sym_ff);
   end

endmodule

`default_nettype wire

[rtl/core/datp_queue.sv]
// short queue of classified characters between front and back end
// depends on datp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module datp_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire datp_pkg::datp_class_type push_item,
   output logic                          q_full,
   output logic                          head_valid,
   output datp_pkg::datp_class_type      head,
   input  wire logic                     pop
);

   localparam int                   DEPTH = datp_pkg::QUEUE_DEPTH;
   localparam int                   AW    = datp_pkg::QUEUE_AW;
   localparam int                   CW    = datp_pkg::QUEUE_CW;
   localparam logic [AW-1:0]        LAST_PTR = AW'(DEPTH - 1);

   datp_pkg::datp_class_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign q_full     = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `ASSERT_PROP(a_count_bound, clock, reset, count_ff <= CW'(DEPTH))
   `ASSERT_NEVER(a_pop_empty, clock, reset, pop && (count_ff == '0))

endmodule

`default_nettype wire

[rtl/core/datp_back.sv]
// back end: sign capture, symbol tracking and the three field scanners
// depends on datp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module datp_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     head_valid,
   input  wire datp_pkg::datp_class_type head,
   output logic                          pop,
   output logic                          snap_valid,
   output datp_pkg::datp_snap_type       snap,
   input  wire logic                     snap_ready
);

   logic                    sign_seen_ff, sign_seen_in;
   logic [7:0]              sign_store_ff, sign_store_in;
   logic                    sign_neg_ff, sign_neg_in;
   logic [2:0]              symbols_ff, symbols_in;
   datp_pkg::datp_scan_type scan_ff [3];
   datp_pkg::datp_scan_type scan_in [3];
   datp_pkg::datp_frac_type frac_ff, frac_in;
   logic                    snap_valid_ff, snap_valid_in;
   datp_pkg::datp_snap_type snap_ff, snap_in;
   logic                    is_d, is_m, is_s;

   function automatic datp_pkg::datp_scan_type scan_feed(datp_pkg::datp_scan_type s,
                                                         datp_pkg::datp_class_type c);
      datp_pkg::datp_scan_type r;
      logic [34:0]             prod;
      r    = s;
      prod = 35'(s.value) * 35'd10 + 35'(c.digit_val);
      if (s.phase != datp_pkg::PH_DONE) begin
         priority if (c.digit) begin
            r.value = (prod[34:31] != 4'd0) ? datp_pkg::MAG_MAX : prod[30:0];
            r.phase = datp_pkg::PH_DIGITS;
         end else if ((s.phase == datp_pkg::PH_SPACE) && c.space) begin
            r.phase = datp_pkg::PH_SPACE;
         end else if ((s.phase == datp_pkg::PH_SPACE) && (c.plus || c.minus)) begin
            r.neg   = c.minus;
            r.phase = datp_pkg::PH_SIGN;
         end else begin
            r.phase = datp_pkg::PH_DONE;
         end
      end
      return r;
   endfunction

   assign pop        = head_valid && (!head.is_last || !snap_valid_ff || snap_ready);
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   assign is_d = !symbols_ff[0] && head.match_d;
   assign is_m = !symbols_ff[1] && head.match_m;
   assign is_s = !symbols_ff[2] && head.match_s;

   always_comb begin
      sign_seen_in  = sign_seen_ff;
      sign_store_in = sign_store_ff;
      sign_neg_in   = sign_neg_ff;
      symbols_in    = symbols_ff;
      scan_in[0]    = scan_ff[0];
      scan_in[1]    = scan_ff[1];
      scan_in[2]    = scan_ff[2];
      frac_in       = frac_ff;
      snap_valid_in = snap_valid_ff && !snap_ready;
      snap_in       = snap_ff;
      if (pop) begin
         if (!sign_seen_ff && head.sign_char) begin
            sign_seen_in  = 1'b1;
            sign_store_in = head.text_char;
            sign_neg_in   = head.sign_neg;
         end

         if (is_d) begin
            scan_in[0].phase = datp_pkg::PH_DONE;
         end else begin
            scan_in[0] = scan_feed(scan_ff[0], head);
         end

         if (symbols_ff[0]) begin
            if (is_m) begin
               scan_in[1].phase = datp_pkg::PH_DONE;
            end else begin
               scan_in[1] = scan_feed(scan_ff[1], head);
            end
         end

         if (symbols_ff[1]) begin
            priority if (is_s) begin
               scan_in[2].phase = datp_pkg::PH_DONE;
               if (frac_ff == datp_pkg::FR_ZERO) begin
                  frac_in = datp_pkg::FR_NONE;
               end
            end else if (scan_ff[2].phase == datp_pkg::PH_DONE) begin
               if (frac_ff == datp_pkg::FR_ZERO) begin
                  if (!head.digit) begin
                     frac_in = datp_pkg::FR_NONE;
                  end else if (head.digit_nz) begin
                     frac_in = datp_pkg::FR_NONZERO;
                  end
               end
            end else begin
               scan_in[2] = scan_feed(scan_ff[2], head);
               if (head.dot) begin
                  frac_in = datp_pkg::FR_ZERO;
               end
            end
         end

         symbols_in = symbols_ff | {is_s, is_m, is_d};

         if (head.is_last) begin
            snap_valid_in       = 1'b1;
            snap_in.is_negative = sign_seen_in && sign_neg_in;
            snap_in.sign_char   = sign_seen_in ? sign_store_in : 8'd0;
            snap_in.symbols     = symbols_in;
            snap_in.deg_val     = scan_in[0].value;
            snap_in.min_neg     = scan_in[1].neg;
            snap_in.min_val     = scan_in[1].value;
            snap_in.sec_neg     = scan_in[2].neg;
            snap_in.sec_val     = scan_in[2].value;
            snap_in.frac_nz     = (frac_in == datp_pkg::FR_NONZERO);
            // start the next text from a clean state
            sign_seen_in  = 1'b0;
            sign_store_in = 8'd0;
            sign_neg_in   = 1'b0;
            symbols_in    = 3'b000;
            frac_in       = datp_pkg::FR_NONE;
            for (int k = 0; k < 3; k++) begin
               scan_in[k] = '{phase: datp_pkg::PH_SPACE, neg: 1'b0, value: 31'd0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sign_seen_ff  <= 1'b0;
         sign_store_ff <= 8'd0;
         sign_neg_ff   <= 1'b0;
         symbols_ff    <= 3'b000;
         frac_ff       <= datp_pkg::FR_NONE;
         snap_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            scan_ff[k] <= '{phase: datp_pkg::PH_SPACE, neg: 1'b0, value: 31'd0};
         end
      end else begin
         sign_seen_ff  <= sign_seen_in;
         sign_store_ff <= sign_store_in;
         sign_neg_ff   <= sign_neg_in;
         symbols_ff    <= symbols_in;
         frac_ff       <= frac_in;
         snap_valid_ff <= snap_valid_in;
         for (int k = 0; k < 3; k++) begin
            scan_ff[k] <= scan_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   `ASSERT_PROP(a_clear_after_last, clock, reset, (pop && head.is_last) |=> (symbols_ff == 3'b000 && !sign_seen_ff && snap_valid_ff))
   `ASSERT_PROP(a_snap_held, clock, reset, (snap_valid_ff && !snap_ready) |=> (snap_valid_ff && $stable(snap_ff)))

endmodule

`default_nettype wire

[rtl/core/datp_format.sv]
// result stage: field gating, 32-bit wrap of negative values, output register
// depends on datp_pkg, datp_if and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module datp_format (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    snap_valid,
   input  wire datp_pkg::datp_snap_type snap,
   output logic                         snap_ready,
   datp_rsp_if.source                   rsp_bus
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic        is_negative_ff;
   logic [7:0]  sign_char_ff;
   logic [30:0] degrees_ff;
   logic [31:0] minutes_ff, minutes_in;
   logic [31:0] seconds_ff, seconds_in;
   logic        has_d, has_m, has_s;
   logic        take;

   assign snap_ready = !rsp_valid_ff || rsp_bus.ready;
   assign take       = snap_valid && snap_ready;

   assign has_d = snap.symbols[0];
   assign has_m = has_d && snap.symbols[1];
   assign has_s = has_m && snap.symbols[2];

   always_comb begin
      minutes_in = 32'd0;
      seconds_in = 32'd0;
      if (has_m) begin
         minutes_in = snap.min_neg ? (32'd0 - {1'b0, snap.min_val}) : {1'b0, snap.min_val};
      end
      if (has_s) begin
         // negative with a nonzero fraction rounds down one more
         seconds_in = snap.sec_neg ? (~{1'b0, snap.sec_val} + {31'd0, !snap.frac_nz})
                                   : {1'b0, snap.sec_val};
      end
      rsp_valid_in = take || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         is_negative_ff <= snap.is_negative;
         sign_char_ff   <= snap.sign_char;
         degrees_ff     <= has_d ? snap.deg_val : 31'd0;
         minutes_ff     <= minutes_in;
         seconds_ff     <= seconds_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.is_negative = is_negative_ff;
   assign rsp_bus.sign_char   = sign_char_ff;
   assign rsp_bus.degrees     = degrees_ff;
   assign rsp_bus.minutes     = minutes_ff;
   assign rsp_bus.seconds     = seconds_ff;

   `ASSERT_PROP(a_take_shows, clock, reset, take |=> rsp_valid_ff)

endmodule

`default_nettype wire

[rtl/core/dms_angle_text_parser.sv]
// angle text parser: characters in one per cycle unless stalled, one result item per text
// the last character passes the queue, its result the snapshot and output registers
// throughput: one character per cycle unless a stalled result holds back the next last
//    character; the two-entry queue holds it and one more, then input stalls
// reset: synchronous, clears queue, scanners and result valid; symbols to 176, 39, 34
`default_nettype none

module dms_angle_text_parser (
   input  wire logic  clock,
   input  wire logic  reset,
   datp_req_if.sink   req_bus,
   datp_csr_if.sink   csr_bus,
   datp_rsp_if.source rsp_bus
);

   logic                     q_full;
   logic                     push;
   datp_pkg::datp_class_type push_item;
   logic                     head_valid;
   datp_pkg::datp_class_type head;
   logic                     pop;
   logic                     snap_valid;
   datp_pkg::datp_snap_type  snap;
   logic                     snap_ready;

   datp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_bus   (csr_bus),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   datp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .q_full     (q_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   datp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_ready (snap_ready)
   );

   datp_format u_format (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_ready (snap_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire
